>>> hw/rtl/tcsm_pkg.sv
// shared constants, types and helper functions of the three-channel sliding median
`timescale 1ns / 1ps
`default_nettype none

package tcsm_pkg;

  localparam int WINDOW   = 5;
  localparam int NCHAN    = 3;
  localparam int RAW_W    = 16;
  localparam int SAMPLE_W = 11;
  localparam int RANK_W   = 3;
  localparam int IDX_W    = $clog2(WINDOW);

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [RANK_W-1:0]   RANK_RESET  = 3'd2;
  localparam logic [SAMPLE_W-1:0] LIMIT_RESET = 11'd1600;

  // register index, taken from byte address bit 2
  localparam logic REG_SELECT_RANK = 1'b0;
  localparam logic REG_CLAMP_LIMIT = 1'b1;

  typedef struct packed {
    logic [RANK_W-1:0]   select_rank;
    logic [SAMPLE_W-1:0] clamp_limit;
  } cfg_t;

  typedef logic [NCHAN-1:0][SAMPLE_W-1:0]  sample_vec_t;
  typedef logic [WINDOW-1:0][SAMPLE_W-1:0] window_t;

  typedef struct packed {
    logic        valid;
    sample_vec_t sample;
  } stage_t;

  // negative samples go to zero, large ones to the limit
  function automatic logic [SAMPLE_W-1:0] clamp_sample(input logic [RAW_W-1:0] raw,
                                                       input logic [SAMPLE_W-1:0] limit);
    logic [SAMPLE_W-1:0] res;
    if (raw[RAW_W-1]) begin
      res = '0;
    end else if (raw[RAW_W-2:0] > (RAW_W-1)'(limit)) begin
      res = limit;
    end else begin
      res = raw[SAMPLE_W-1:0];
    end
    return res;
  endfunction

  // ranks at or above the window length pick the largest entry
  function automatic logic [IDX_W-1:0] sat_rank(input logic [RANK_W-1:0] rank);
    int unsigned r;
    r = 32'(rank);
    if (r >= WINDOW) begin
      r = WINDOW - 1;
    end
    return IDX_W'(r);
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/tcsm_in_if.sv
// input channel: three raw distance samples per transaction
`timescale 1ns / 1ps
`default_nettype none

interface tcsm_in_if import tcsm_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [RAW_W-1:0] distance_ch1;
  logic signed [RAW_W-1:0] distance_ch2;
  logic signed [RAW_W-1:0] distance_ch3;

  modport source (output valid, output distance_ch1, output distance_ch2,
                  output distance_ch3, input ready);
  modport sink   (input valid, input distance_ch1, input distance_ch2,
                  input distance_ch3, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/tcsm_out_if.sv
// output channel: three filtered distances per transaction
`timescale 1ns / 1ps
`default_nettype none

interface tcsm_out_if import tcsm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] filtered_ch1;
  logic [SAMPLE_W-1:0] filtered_ch2;
  logic [SAMPLE_W-1:0] filtered_ch3;

  modport source (output valid, output filtered_ch1, output filtered_ch2,
                  output filtered_ch3, input ready);
  modport sink   (input valid, input filtered_ch1, input filtered_ch2,
                  input filtered_ch3, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/tcsm_cfg_regs.sv
// apb configuration registers: select rank and clamp limit
`timescale 1ns / 1ps
`default_nettype none

module tcsm_cfg_regs import tcsm_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  output cfg_t                       cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.select_rank <= RANK_RESET;
      cfg.clamp_limit <= LIMIT_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        REG_SELECT_RANK: cfg.select_rank <= pwdata[RANK_W-1:0];
        REG_CLAMP_LIMIT: cfg.clamp_limit <= pwdata[SAMPLE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_SELECT_RANK: prdata = APB_DATA_W'(cfg.select_rank);
      REG_CLAMP_LIMIT: prdata = APB_DATA_W'(cfg.clamp_limit);
      default:         prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/tcsm_input_stage.sv
// input register: clamps the three samples as the transaction is taken
`timescale 1ns / 1ps
`default_nettype none

module tcsm_input_stage import tcsm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  tcsm_in_if.sink          in_ch,
  input  wire logic [SAMPLE_W-1:0] clamp_limit,
  input  wire logic        take,
  output stage_t           stage
);

  logic accept;

  assign in_ch.ready = !stage.valid || take;
  assign accept      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (accept) begin
      stage.valid <= 1'b1;
    end else if (take) begin
      stage.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage.sample[0] <= clamp_sample(in_ch.distance_ch1, clamp_limit);
      stage.sample[1] <= clamp_sample(in_ch.distance_ch2, clamp_limit);
      stage.sample[2] <= clamp_sample(in_ch.distance_ch3, clamp_limit);
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/tcsm_rank_select.sv
// picks the entry of one window at a given rank of its ascending order
`timescale 1ns / 1ps
`default_nettype none

module tcsm_rank_select import tcsm_pkg::*; (
  input  wire window_t              win,
  input  wire logic [IDX_W-1:0]     rank,
  output logic      [SAMPLE_W-1:0]  value
);

  // each entry's place in a stable sort: smaller entries, plus equal ones before it
  always_comb begin
    logic [WINDOW-1:0] before_vec;
    logic [IDX_W-1:0]  pos;
    value = '0;
    for (int i = 0; i < WINDOW; i++) begin
      for (int j = 0; j < WINDOW; j++) begin
        before_vec[j] = (win[j] < win[i]) || ((win[j] == win[i]) && (j < i));
      end
      pos = IDX_W'($countones(before_vec));
      if (pos == rank) begin
        value = value | win[i];
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/tcsm_window_core.sv
// per-channel circular windows, shared write pointer and result register
`timescale 1ns / 1ps
`default_nettype none

module tcsm_window_core import tcsm_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire stage_t stage,
  input  wire logic [RANK_W-1:0] select_rank,
  output logic      take,
  tcsm_out_if.source out_ch
);

  window_t             win      [NCHAN];
  window_t             win_next [NCHAN];
  logic [IDX_W-1:0]    wr_pos;
  logic [IDX_W-1:0]    wr_pos_next;
  logic [IDX_W-1:0]    rank_eff;
  sample_vec_t         result;
  logic                out_valid;
  logic [SAMPLE_W-1:0] out_data [NCHAN];

  assign take     = stage.valid && (!out_valid || out_ch.ready);
  assign rank_eff = sat_rank(select_rank);

  assign wr_pos_next = (32'(wr_pos) >= WINDOW - 1) ? '0 : wr_pos + IDX_W'(1);

  // ranking sees the window with the new sample already in place
  always_comb begin
    for (int c = 0; c < NCHAN; c++) begin
      win_next[c] = win[c];
      win_next[c][wr_pos] = stage.sample[c];
    end
  end

  for (genvar c = 0; c < NCHAN; c++) begin : g_chan
    tcsm_rank_select u_rank (
      .win   (win_next[c]),
      .rank  (rank_eff),
      .value (result[c])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_pos <= '0;
      for (int c = 0; c < NCHAN; c++) begin
        win[c] <= '0;
      end
    end else if (take) begin
      wr_pos <= wr_pos_next;
      for (int c = 0; c < NCHAN; c++) begin
        win[c] <= win_next[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      for (int c = 0; c < NCHAN; c++) begin
        out_data[c] <= result[c];
      end
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.filtered_ch1 = out_data[0];
  assign out_ch.filtered_ch2 = out_data[1];
  assign out_ch.filtered_ch3 = out_data[2];

endmodule

`default_nettype wire

>>> hw/rtl/three_channel_sliding_median.sv
// top level of the three-channel sliding rank filter
//
//   channel   role     contents per transaction
//   in_ch     sink     distance_ch1..3, signed q11.4 cm, 16 bits each
//   out_ch    source   filtered_ch1..3, unsigned q7.4 cm, 11 bits each
//   apb       slave    select_rank at 0x0, clamp_limit at 0x4
//
// one transaction per cycle sustained while out_ch is not stalled; an input is
// clamped into the input register as it is taken, then passes the window write
// and rank compare network into the result register
// synchronous reset clears windows, write pointer and valid flags and loads the config defaults
// a stalled result holds, and the input register keeps taking while it moves
`timescale 1ns / 1ps
`default_nettype none

module three_channel_sliding_median import tcsm_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  tcsm_in_if.sink                    in_ch,
  tcsm_out_if.source                 out_ch,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready
);

  cfg_t   cfg;
  stage_t stage;
  logic   take;

  tcsm_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tcsm_input_stage u_input (
    .clk         (clk),
    .rst         (rst),
    .in_ch       (in_ch),
    .clamp_limit (cfg.clamp_limit),
    .take        (take),
    .stage       (stage)
  );

  tcsm_window_core u_core (
    .clk         (clk),
    .rst         (rst),
    .stage       (stage),
    .select_rank (cfg.select_rank),
    .take        (take),
    .out_ch      (out_ch)
  );

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
// testbench for the three-channel sliding rank filter: stimulus, prediction and checking
`timescale 1ns / 1ps

module tb_top;
  import tcsm_pkg::*;

  typedef logic [NCHAN-1:0][RAW_W-1:0] raw_vec_t;

  // predicts the selected-rank output of each channel window
  class rank_filter_model;
    logic [SAMPLE_W-1:0] history [NCHAN][WINDOW];
    int unsigned         slot;
    logic [RANK_W-1:0]   rank;
    logic [SAMPLE_W-1:0] limit;
    sample_vec_t         expected_filtered [$];
    int                  mismatches;
    int                  n_samples;
    int                  n_results;

    function new();
      foreach (history[c, i]) history[c][i] = '0;
      slot       = 0;
      rank       = RANK_RESET;
      limit      = LIMIT_RESET;
      mismatches = 0;
      n_samples  = 0;
      n_results  = 0;
    endfunction

    function logic [SAMPLE_W-1:0] limited(logic [RAW_W-1:0] raw);
      int v;
      v = int'($signed(raw));
      if (v < 0) return '0;
      if (v > int'(limit)) return limit;
      return SAMPLE_W'(v);
    endfunction

    // entry whose rank span covers the wanted rank
    function logic [SAMPLE_W-1:0] ranked(int ch);
      int r;
      int below;
      int up_to;
      r = (int'(rank) >= WINDOW) ? WINDOW - 1 : int'(rank);
      for (int i = 0; i < WINDOW; i++) begin
        below = 0;
        up_to = 0;
        for (int j = 0; j < WINDOW; j++) begin
          if (history[ch][j] < history[ch][i]) below++;
          if (history[ch][j] <= history[ch][i]) up_to++;
        end
        if (below <= r && r < up_to) return history[ch][i];
      end
      return '0;
    endfunction

    function void take_sample(raw_vec_t raws);
      sample_vec_t exp_vec;
      for (int c = 0; c < NCHAN; c++) history[c][slot] = limited(raws[c]);
      slot = (slot + 1 >= WINDOW) ? 0 : slot + 1;
      for (int c = 0; c < NCHAN; c++) exp_vec[c] = ranked(c);
      expected_filtered.push_back(exp_vec);
      n_samples++;
    endfunction

    function void check_filtered(sample_vec_t got);
      sample_vec_t exp_vec;
      n_results++;
      if (expected_filtered.size() == 0) begin
        $error("filtered result with no input pending: %0d %0d %0d", got[0], got[1], got[2]);
        mismatches++;
        return;
      end
      exp_vec = expected_filtered.pop_front();
      for (int c = 0; c < NCHAN; c++) begin
        if (got[c] !== exp_vec[c]) begin
          $error("filtered_ch%0d: expected %0d, got %0d", c + 1, exp_vec[c], got[c]);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  bit                    calm = 1'b0;
  int                    n_settings = 0;

  rank_filter_model sb = new();

  tcsm_in_if  in_if ();
  tcsm_out_if out_if ();

  three_channel_sliding_median u_dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_if),
    .out_ch  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #2 clk = ~clk;

  initial begin
    in_if.valid        = 1'b0;
    in_if.distance_ch1 = '0;
    in_if.distance_ch2 = '0;
    in_if.distance_ch3 = '0;
    out_if.ready       = 1'b0;
  end

  initial begin
    #4_000_000;
    $display("timeout with %0d results outstanding", sb.expected_filtered.size());
    $display("Some tests failed");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_if.valid && in_if.ready) begin
        sb.take_sample({in_if.distance_ch3, in_if.distance_ch2, in_if.distance_ch1});
      end
      if (out_if.valid && out_if.ready) begin
        sb.check_filtered({out_if.filtered_ch3, out_if.filtered_ch2, out_if.filtered_ch1});
      end
    end
  end

  // mostly short gaps, now and then a long one, none in calm stretches
  function automatic int idle_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // receiver stalls
  initial begin
    int run;
    int gap;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      run = $urandom_range(1, 16);
      out_if.ready <= 1'b1;
      repeat (run) @(negedge clk);
      gap = idle_gap();
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  end

  function automatic raw_vec_t rv(logic [RAW_W-1:0] a, logic [RAW_W-1:0] b,
                                  logic [RAW_W-1:0] c);
    return {c, b, a};
  endfunction

  task automatic send_item(input raw_vec_t raws);
    int gap;
    gap = idle_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.distance_ch1 <= raws[0];
    in_if.distance_ch2 <= raws[1];
    in_if.distance_ch3 <= raws[2];
    do @(posedge clk); while (!in_if.ready);
  endtask

  // drop valid and let every pending result come out
  task automatic drain();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (sb.expected_filtered.size() != 0) @(posedge clk);
  endtask

  task automatic reg_write(input logic reg_idx, input logic [APB_DATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'({reg_idx, 2'b00});
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic reg_check(input logic reg_idx, input logic [APB_DATA_W-1:0] want,
                           input string field);
    logic [APB_DATA_W-1:0] got;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= APB_ADDR_W'({reg_idx, 2'b00});
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      sb.mismatches++;
    end
  endtask

  // upper pwdata bits are noise the block must ignore
  task automatic set_filter(input logic [RANK_W-1:0] rank, input logic [SAMPLE_W-1:0] limit);
    logic [APB_DATA_W-1:0] noise;
    noise = $urandom();
    reg_write(REG_SELECT_RANK, {noise[APB_DATA_W-1:RANK_W], rank});
    noise = $urandom();
    reg_write(REG_CLAMP_LIMIT, {noise[APB_DATA_W-1:SAMPLE_W], limit});
    sb.rank  = rank;
    sb.limit = limit;
    reg_check(REG_SELECT_RANK, APB_DATA_W'(rank), "select_rank");
    reg_check(REG_CLAMP_LIMIT, APB_DATA_W'(limit), "clamp_limit");
    n_settings++;
  endtask

  // one raw sample, weighted toward the clamp edges and repeats
  function automatic logic [RAW_W-1:0] pick_raw(logic [RAW_W-1:0] prev);
    int lim;
    lim = int'(sb.limit);
    case ($urandom_range(0, 9))
      0, 1:    return RAW_W'($urandom_range(0, 65535));
      2:       return RAW_W'(-$urandom_range(1, 64));
      3:       return RAW_W'(lim - 2 + $urandom_range(0, 4));
      4:       return RAW_W'($urandom_range(0, 1));
      5:       return RAW_W'($urandom_range(2048, 32767));
      6:       return prev;
      default: return RAW_W'($urandom_range(0, lim));
    endcase
  endfunction

  initial begin
    raw_vec_t    last;
    logic [RANK_W-1:0]   ranks  [8];
    logic [SAMPLE_W-1:0] limits [8];

    ranks  = '{3'd2, 3'd0, 3'd4, 3'd7, 3'd3, 3'd1, 3'd5, 3'd2};
    limits = '{11'd1600, 11'd2047, 11'd0, 11'd1600,
               11'd1, 11'd100, 11'd2047, 11'd800};

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings, windows still partly empty
    send_item(rv(16'd0, 16'd0, 16'd0));
    send_item(rv(16'h8000, 16'h7FFF, 16'hFFFF));
    send_item(rv(16'd1600, 16'd1601, 16'd1599));
    send_item(rv(16'h4000, 16'h7FFF, 16'd2047));
    send_item(rv(16'hFFFF, 16'd0, 16'd1));
    send_item(rv(16'd800, 16'd800, 16'd800));
    send_item(rv(16'd800, 16'd800, 16'd800));
    send_item(rv(16'd800, 16'd5, 16'd1600));
    drain();

    // rank beyond the window and the widest clamp
    set_filter(3'd7, 11'd2047);
    send_item(rv(16'd2047, 16'd2048, 16'h7FFF));
    send_item(rv(16'h8000, 16'd2046, 16'd1));
    send_item(rv(16'd2047, 16'd2047, 16'd2047));
    send_item(rv(16'h0555, 16'h02AA, 16'h7800));
    drain();

    // everything clamps to zero
    set_filter(3'd0, 11'd0);
    send_item(rv(16'd100, 16'hFFFB, 16'h7FFF));
    send_item(rv(16'd0, 16'd1, 16'd2));
    drain();

    set_filter(3'd4, 11'd1600);
    send_item(rv(16'd1234, 16'd56, 16'd789));
    send_item(rv(16'h2AAA, 16'h5555, 16'h8001));
    send_item(rv(16'd3, 16'd1600, 16'd0));

    last = '0;
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      if (ph < 6) begin
        set_filter(ranks[ph], limits[ph]);
      end else begin
        set_filter(RANK_W'($urandom_range(0, 7)), SAMPLE_W'($urandom_range(0, 2047)));
      end
      for (int k = 0; k < 85; k++) begin
        calm = ((k % 40) >= 30);
        for (int c = 0; c < NCHAN; c++) last[c] = pick_raw(last[c]);
        send_item(last);
      end
      calm = 1'b0;
    end

    drain();
    repeat (10) @(posedge clk);
    $display("checked %0d filtered results from %0d input transactions", sb.n_results,
             sb.n_samples);
    $display("%0d rank/clamp settings, ranks 0..7 and limits 0..2047", n_settings);
    if (sb.mismatches == 0 && sb.expected_filtered.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/tcsm_pkg.sv
hw/rtl/tcsm_in_if.sv
hw/rtl/tcsm_out_if.sv
hw/rtl/tcsm_cfg_regs.sv
hw/rtl/tcsm_input_stage.sv
hw/rtl/tcsm_rank_select.sv
hw/rtl/tcsm_window_core.sv
hw/rtl/three_channel_sliding_median.sv
tb/sv/tb_top.sv
